/* src/slcs_pkg.sv */
// shared types and codes of the sorted list cursor seek unit
`default_nettype none
package slcs_pkg;

    localparam int OPCODE_W  = 4;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;

    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_APPEND  = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_FIRST   = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_NEXT    = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_LAST    = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_PREV    = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_EXACT   = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_OR_NEXT = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_AFTER   = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_OR_PREV = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_BEFORE  = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

    typedef enum logic [1:0] {
        POS_BEFORE = 2'd0,
        POS_ON     = 2'd1,
        POS_AFTER  = 2'd2
    } t_pos_kind;

    typedef struct packed {
        logic                found;
        logic [VALUE_W-1:0]  ordinal;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage
`default_nettype wire

/* src/slcs_cmd_if.sv */
// command channel: opcode and value with valid/ready
`default_nettype none
interface slcs_cmd_if;
    import slcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface
`default_nettype wire

/* src/slcs_res_if.sv */
// result channel: found, ordinal and status with valid/ready
`default_nettype none
interface slcs_res_if;
    import slcs_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [VALUE_W-1:0]  ordinal;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output found, output ordinal, output status, input ready);
    modport sink   (input valid, input found, input ordinal, input status, output ready);
endinterface
`default_nettype wire

/* src/sorted_list_cursor_seek_unit.sv */
// top level of the sorted list cursor seek unit: sequencer, list memory, output register
//
//   channel  dir  handshake          payload
//   i_cmd    in   valid/ready        opcode[3:0], value[63:0]
//   o_res    out  valid/ready        found, ordinal[63:0], status[1:0]
//
// one item at a time; clear, append and unused opcodes go from idle straight to emit,
// navigation reads the entry it lands on, a seek runs a binary search, then resolves and
// reads; the search uses the single read port of the list memory, one probe per cycle
// the output register holds a result while the next item is taken and worked on
// synchronous active-low reset empties the list and puts the cursor before the start
`default_nettype none
module sorted_list_cursor_seek_unit #(
    parameter int LIST_DEPTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slcs_cmd_if.sink  i_cmd,
    slcs_res_if.source o_res
);
    import slcs_pkg::*;

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               r_out_valid;
    t_result            r_out;

    slcs_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    slcs_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register takes a new item once the previous one is gone or leaving
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.found   = r_out.found;
    assign o_res.ordinal = r_out.ordinal;
    assign o_res.status  = r_out.status;

endmodule
`default_nettype wire

/* src/slcs_mem.sv */
// list storage: one write port, one read port with registered read data
`default_nettype none
module slcs_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [slcs_pkg::VALUE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                i_raddr,
    output logic      [slcs_pkg::VALUE_W-1:0] o_rdata
);
    import slcs_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/slcs_ctrl.sv */
// cursor sequencer: list bookkeeping, navigation and binary search over the memory
`default_nettype none
module slcs_ctrl #(
    parameter int LIST_DEPTH = 1024,
    parameter int IW         = 10,
    parameter int CW         = 11
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    slcs_cmd_if.sink                          i_cmd,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output slcs_pkg::t_result                 o_res,
    output logic                              o_mem_we,
    output logic      [IW-1:0]                o_mem_waddr,
    output logic      [slcs_pkg::VALUE_W-1:0] o_mem_wdata,
    output logic      [IW-1:0]                o_mem_raddr,
    input  wire logic [slcs_pkg::VALUE_W-1:0] i_mem_rdata
);
    import slcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_RSLV,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_pos_kind     kind;
        logic [IW-1:0] index;
    } t_cursor;

    localparam t_cursor CUR_BEFORE = '{kind: POS_BEFORE, index: '0};
    localparam t_cursor CUR_AFTER  = '{kind: POS_AFTER, index: '0};

    function automatic t_cursor go_to(input logic [CW-1:0] idx, input logic [CW-1:0] cnt);
        t_cursor c;
        if (idx < cnt) begin
            c.kind  = POS_ON;
            c.index = idx[IW-1:0];
        end else begin
            c = CUR_AFTER;
        end
        return c;
    endfunction

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    t_cursor             r_cur, n_cur;
    logic [VALUE_W-1:0]  r_last, n_last;
    logic [VALUE_W-1:0]  r_cur_ord, n_cur_ord;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [VALUE_W-1:0]  r_target, n_target;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [IW-1:0]       r_mid, n_mid;
    logic                r_chk_eq, n_chk_eq;
    t_result             r_res, n_res;

    logic                accept;
    logic                go_right;
    logic [CW-1:0]       s_lo, s_hi, s_mid;
    t_cursor             c;
    t_result             cur_report;

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign accept       = i_cmd.valid && (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_EMIT);
    assign o_res        = r_res;
    assign o_mem_waddr  = r_count[IW-1:0];
    assign o_mem_wdata  = i_cmd.value;

    // report of an unmoved cursor
    always_comb begin
        cur_report.found   = (r_cur.kind == POS_ON);
        cur_report.ordinal = (r_cur.kind == POS_ON) ? r_cur_ord : '0;
        cur_report.status  = ST_OK;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_cur     = r_cur;
        n_last    = r_last;
        n_cur_ord = r_cur_ord;
        n_op      = r_op;
        n_target  = r_target;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_chk_eq  = r_chk_eq;
        n_res     = r_res;
        o_mem_we  = 1'b0;
        o_mem_raddr = r_mid;
        c         = r_cur;
        go_right  = 1'b0;
        s_lo      = r_lo;
        s_hi      = r_hi;
        s_mid     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_cmd.opcode;
                    n_target = i_cmd.value;
                    n_chk_eq = 1'b0;
                    n_state  = S_EMIT;
                    n_res    = cur_report;
                    unique case (i_cmd.opcode) inside
                        OP_CLEAR: begin
                            n_count = '0;
                            n_cur   = CUR_BEFORE;
                            n_res   = '{found: 1'b0, ordinal: '0, status: ST_OK};
                        end
                        OP_APPEND: begin
                            if (r_count == CW'(LIST_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else if (r_count != '0 && i_cmd.value < r_last) begin
                                n_res.status = ST_ORDER;
                            end else begin
                                o_mem_we = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_last   = i_cmd.value;
                            end
                        end
                        OP_FIRST, OP_NEXT, OP_LAST, OP_PREV: begin
                            case (i_cmd.opcode)
                                OP_FIRST: c = go_to('0, r_count);
                                OP_NEXT: begin
                                    if (r_cur.kind == POS_BEFORE) begin
                                        c = go_to('0, r_count);
                                    end else if (r_cur.kind == POS_ON) begin
                                        c = go_to(CW'(r_cur.index) + CW'(1), r_count);
                                    end
                                end
                                OP_LAST: begin
                                    c = (r_count == '0) ? CUR_BEFORE
                                                        : go_to(r_count - CW'(1), r_count);
                                end
                                default: begin
                                    if (r_cur.kind == POS_AFTER) begin
                                        c = (r_count == '0) ? CUR_BEFORE
                                                            : go_to(r_count - CW'(1), r_count);
                                    end else if (r_cur.kind == POS_ON) begin
                                        c = (r_cur.index == '0) ? CUR_BEFORE
                                            : go_to(CW'(r_cur.index) - CW'(1), r_count);
                                    end
                                end
                            endcase
                            n_cur = c;
                            if (c.kind == POS_ON) begin
                                o_mem_raddr = c.index;
                                n_state     = S_READ;
                            end else begin
                                n_res = '{found: 1'b0, ordinal: '0, status: ST_OK};
                            end
                        end
                        OP_EXACT, OP_OR_NEXT, OP_AFTER, OP_OR_PREV, OP_BEFORE: begin
                            n_lo = '0;
                            n_hi = r_count;
                            if (r_count == '0) begin
                                n_state = S_RSLV;
                            end else begin
                                s_mid       = r_count >> 1;
                                n_mid       = s_mid[IW-1:0];
                                o_mem_raddr = s_mid[IW-1:0];
                                n_state     = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH: begin
                // read data belongs to r_mid; pick the half and issue the next probe
                if (r_op == OP_AFTER || r_op == OP_OR_PREV) begin
                    go_right = (i_mem_rdata <= r_target);
                end else begin
                    go_right = (i_mem_rdata < r_target);
                end
                if (go_right) begin
                    s_lo = CW'(r_mid) + CW'(1);
                end else begin
                    s_hi = CW'(r_mid);
                end
                s_mid = s_lo + ((s_hi - s_lo) >> 1);
                n_lo  = s_lo;
                n_hi  = s_hi;
                n_mid = s_mid[IW-1:0];
                o_mem_raddr = s_mid[IW-1:0];
                if (!(s_lo < s_hi)) begin
                    n_state = S_RSLV;
                end
            end
            S_RSLV: begin
                case (r_op) inside
                    OP_EXACT, OP_OR_NEXT, OP_AFTER: c = go_to(r_lo, r_count);
                    default: c = (r_lo == '0) ? CUR_BEFORE : go_to(r_lo - CW'(1), r_count);
                endcase
                n_chk_eq = (r_op == OP_EXACT);
                n_cur    = c;
                if (c.kind == POS_ON) begin
                    o_mem_raddr = c.index;
                    n_state     = S_READ;
                end else begin
                    n_res   = '{found: 1'b0, ordinal: '0, status: ST_OK};
                    n_state = S_EMIT;
                end
            end
            S_READ: begin
                if (r_chk_eq && i_mem_rdata != r_target) begin
                    n_cur = CUR_AFTER;
                    n_res = '{found: 1'b0, ordinal: '0, status: ST_OK};
                end else begin
                    n_cur_ord = i_mem_rdata;
                    n_res     = '{found: 1'b1, ordinal: i_mem_rdata, status: ST_OK};
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cur   <= CUR_BEFORE;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cur   <= n_cur;
        end
        r_last    <= n_last;
        r_cur_ord <= n_cur_ord;
        r_op      <= n_op;
        r_target  <= n_target;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_chk_eq  <= n_chk_eq;
        r_res     <= n_res;
    end

endmodule
`default_nettype wire

/* tb/sv/sorted_list_cursor_seek_checker.sv */
// checker of the sorted list cursor seek unit: shadow list and cursor, result comparison
`default_nettype none
module sorted_list_cursor_seek_checker
    import slcs_pkg::*;
#(
    parameter int LIST_DEPTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slcs_cmd_if       i_cmd,
    slcs_res_if       i_res,
    output int        o_fail_count,
    output int        o_pending
);

    logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int unsigned        list_len;
    t_pos_kind          cursor_kind;
    int unsigned        cursor_idx;
    t_result            cursor_reports [$];

    task automatic report_failure(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    // first index whose entry is >= target, or > target when strict
    function automatic int unsigned bound_index(input logic [VALUE_W-1:0] target,
                                                input bit strict);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = list_len;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (strict ? (list_mem[mid] <= target) : (list_mem[mid] < target)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic void park_before();
        cursor_kind = POS_BEFORE;
        cursor_idx  = 0;
    endfunction

    // an index past the end lands after the end
    function automatic void place_cursor(input int unsigned idx);
        if (idx < list_len) begin
            cursor_kind = POS_ON;
            cursor_idx  = idx;
        end else begin
            cursor_kind = POS_AFTER;
            cursor_idx  = 0;
        end
    endfunction

    function automatic void go_to_last();
        if (list_len == 0) begin
            park_before();
        end else begin
            place_cursor(list_len - 1);
        end
    endfunction

    function automatic t_result cursor_after_command(input logic [OPCODE_W-1:0] op,
                                                     input logic [VALUE_W-1:0]  v);
        t_result     r;
        int unsigned lb;
        int unsigned ub;
        r.status = ST_OK;
        case (op)
            OP_CLEAR: begin
                list_len = 0;
                park_before();
            end
            OP_APPEND: begin
                // full is checked ahead of order
                if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (list_len > 0 && v < list_mem[list_len - 1]) begin
                    r.status = ST_ORDER;
                end else begin
                    list_mem[list_len] = v;
                    list_len++;
                end
            end
            OP_FIRST: place_cursor(0);
            OP_NEXT: begin
                if (cursor_kind == POS_BEFORE) begin
                    place_cursor(0);
                end else if (cursor_kind == POS_ON) begin
                    place_cursor(cursor_idx + 1);
                end
            end
            OP_LAST: go_to_last();
            OP_PREV: begin
                if (cursor_kind == POS_AFTER) begin
                    go_to_last();
                end else if (cursor_kind == POS_ON) begin
                    if (cursor_idx == 0) begin
                        park_before();
                    end else begin
                        place_cursor(cursor_idx - 1);
                    end
                end
            end
            OP_EXACT: begin
                lb = bound_index(v, 1'b0);
                if (lb < list_len && list_mem[lb] == v) begin
                    place_cursor(lb);
                end else begin
                    place_cursor(list_len);
                end
            end
            OP_OR_NEXT: place_cursor(bound_index(v, 1'b0));
            OP_AFTER: place_cursor(bound_index(v, 1'b1));
            OP_OR_PREV: begin
                ub = bound_index(v, 1'b1);
                if (ub == 0) begin
                    park_before();
                end else begin
                    place_cursor(ub - 1);
                end
            end
            OP_BEFORE: begin
                lb = bound_index(v, 1'b0);
                if (lb == 0) begin
                    park_before();
                end else begin
                    place_cursor(lb - 1);
                end
            end
            default: ;
        endcase
        r.found   = (cursor_kind == POS_ON) && (cursor_idx < list_len);
        r.ordinal = r.found ? list_mem[cursor_idx] : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            list_len = 0;
            park_before();
            cursor_reports.delete();
        end else begin
            // the result side first: a result never belongs to an item taken at the same edge
            if (i_res.valid && i_res.ready) begin
                got.found   = i_res.found;
                got.ordinal = i_res.ordinal;
                got.status  = i_res.status;
                if (cursor_reports.size() == 0) begin
                    report_failure($sformatf("result with nothing expected: found %0b ordinal %0h",
                                             got.found, got.ordinal));
                end else begin
                    want = cursor_reports.pop_front();
                    if (got.found !== want.found) begin
                        report_failure($sformatf("found %0b, expected %0b",
                                                 got.found, want.found));
                    end
                    if (got.ordinal !== want.ordinal) begin
                        report_failure($sformatf("ordinal %0h, expected %0h",
                                                 got.ordinal, want.ordinal));
                    end
                    if (got.status !== want.status) begin
                        report_failure($sformatf("status %0d, expected %0d",
                                                 got.status, want.status));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                cursor_reports.insert(cursor_reports.size(),
                                      cursor_after_command(i_cmd.opcode, i_cmd.value));
            end
        end
        o_pending <= cursor_reports.size();
    end

endmodule
`default_nettype wire

/* tb/sv/sorted_list_cursor_seek_unit_test.sv */
// test top of the sorted list cursor seek unit: clock, reset, command stimulus and verdict
`default_nettype none
module sorted_list_cursor_seek_unit_test;
    import slcs_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    localparam int RX_STEADY = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   hold_requests;
    int   holds_done;
    int   burst_left;
    int   sent;

    // what the stimulus side believes the list holds, for targets and ordered appends
    logic [VALUE_W-1:0] stored_vals [$];

    slcs_cmd_if cmd_ch ();
    slcs_res_if res_ch ();

    sorted_list_cursor_seek_unit #(
        .LIST_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    sorted_list_cursor_seek_checker #(
        .LIST_DEPTH(DEPTH)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .i_res       (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL sorted_list_cursor_seek_unit");
        $finish;
    end

    // result side: stall patterns of its own, and long hold-offs on request
    initial begin
        int mode;
        int mode_left;
        res_ch.ready <= 1'b0;
        mode      = RX_STEADY;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(RX_STEADY, RX_SPARSE);
                    mode_left = $urandom_range(5, 80);
                end
                mode_left--;
                case (mode)
                    RX_STEADY: res_ch.ready <= 1'b1;
                    RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                    default:   res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic issue(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.opcode <= op;
        cmd_ch.value  <= v;
        burst_left--;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent++;
        if (op == OP_CLEAR) begin
            stored_vals.delete();
        end else if (op == OP_APPEND && stored_vals.size() < DEPTH &&
                     (stored_vals.size() == 0 || v >= stored_vals[$])) begin
            stored_vals.insert(stored_vals.size(), v);
        end
    endtask

    task automatic pause_for_results();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // a value that keeps the list in order, duplicates included
    function automatic logic [VALUE_W-1:0] next_ordinal();
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] incr;
        logic [VALUE_W:0]   total;
        if (stored_vals.size() == 0) begin
            case ($urandom_range(0, 2))
                0:       return VALUE_W'($urandom_range(0, 100));
                1:       return {32'd0, $urandom()};
                default: return {$urandom(), $urandom()};
            endcase
        end
        base = stored_vals[$];
        case ($urandom_range(0, 7))
            0, 1:    incr = '0;
            2, 3, 4: incr = VALUE_W'($urandom_range(1, 3));
            5, 6:    incr = {32'd0, $urandom()};
            default: incr = {$urandom(), $urandom()} >> $urandom_range(1, 16);
        endcase
        total = base + incr;
        return total[VALUE_W] ? ALL_ONES : total[VALUE_W-1:0];
    endfunction

    // seek targets hit stored values, their neighbors, the extremes or anything
    function automatic logic [VALUE_W-1:0] pick_target();
        logic [VALUE_W-1:0] pick;
        if (stored_vals.size() == 0 || $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return ALL_ONES;
                default: return {$urandom(), $urandom()};
            endcase
        end
        pick = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
        case ($urandom_range(0, 2))
            0:       return pick;
            1:       return (pick == '0) ? pick : pick - 1'b1;
            default: return (pick == ALL_ONES) ? pick : pick + 1'b1;
        endcase
    endfunction

    task automatic browse(input int count);
        logic [OPCODE_W-1:0] op;
        repeat (count) begin
            op = OPCODE_W'($urandom_range(OP_FIRST, OP_BEFORE));
            issue(op, (op >= OP_EXACT) ? pick_target() : {$urandom(), $urandom()});
        end
    endtask

    initial begin
        int start;
        int holds_asked;
        bit drained;
        bit fill_done;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.opcode <= OP_CLEAR;
        cmd_ch.value  <= '0;
        i_rst_n       <= 1'b0;
        burst_left  = 0;
        sent        = 0;
        holds_asked = 0;
        drained     = 1'b0;
        fill_done   = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: every move falls off one end or the other
        issue(OP_NEXT, '0);
        issue(OP_PREV, '0);
        issue(OP_PREV, '0);
        issue(OP_FIRST, '0);
        issue(OP_LAST, '0);
        issue(OP_EXACT, '0);
        issue(OP_OR_PREV, ALL_ONES);
        issue(4'hF, ALL_ONES);
        // list 0, max, max with an out-of-order append between
        issue(OP_APPEND, '0);
        issue(OP_APPEND, ALL_ONES);
        issue(OP_APPEND, 64'd5);
        issue(OP_APPEND, ALL_ONES);
        issue(OP_EXACT, ALL_ONES);
        issue(OP_NEXT, '0);
        issue(OP_NEXT, '0);
        issue(OP_NEXT, '0);
        issue(OP_PREV, '0);
        issue(OP_BEFORE, '0);
        issue(OP_OR_PREV, '0);
        issue(OP_AFTER, ALL_ONES);
        issue(OP_OR_NEXT, 64'd1);
        issue(OP_BEFORE, ALL_ONES);
        issue(OP_EXACT, 64'd7);
        issue(4'd11, 64'd3);
        issue(OP_CLEAR, ALL_ONES);
        issue(OP_LAST, '0);

        start = sent;
        while (sent - start < RANDOM_ITEMS) begin
            if ((holds_asked == 0 && sent - start >= 150) ||
                (holds_asked == 1 && sent - start >= 1400)) begin
                hold_requests <= hold_requests + 1;
                holds_asked++;
            end
            if (!drained && sent - start >= 700) begin
                pause_for_results();
                drained = 1'b1;
            end
            if (!fill_done && sent - start >= 250) begin
                // fill to the brim, then push past it
                fill_done = 1'b1;
                issue(OP_CLEAR, {$urandom(), $urandom()});
                while (stored_vals.size() < DEPTH) begin
                    issue(OP_APPEND, next_ordinal());
                end
                issue(OP_APPEND, ALL_ONES);
                // full wins over out of order
                issue(OP_APPEND, '0);
                issue(OP_LAST, '0);
                issue(OP_NEXT, '0);
                issue(OP_PREV, '0);
                browse(30);
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    issue(OPCODE_W'($urandom_range(0, 15)), {$urandom(), $urandom()});
                end
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    issue(OP_CLEAR, {$urandom(), $urandom()});
                end
                repeat ($urandom_range(0, 24)) begin
                    if (stored_vals.size() != 0 && stored_vals[$] != '0 &&
                        $urandom_range(0, 11) == 0) begin
                        issue(OP_APPEND, {$urandom(), $urandom()} % stored_vals[$]);
                    end else begin
                        issue(OP_APPEND, next_ordinal());
                    end
                end
                browse($urandom_range(4, 20));
            end
        end

        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS sorted_list_cursor_seek_unit");
        end else begin
            $display("FAIL sorted_list_cursor_seek_unit");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
src/slcs_pkg.sv
src/slcs_cmd_if.sv
src/slcs_res_if.sv
src/slcs_mem.sv
src/slcs_ctrl.sv
src/sorted_list_cursor_seek_unit.sv
tb/sv/sorted_list_cursor_seek_checker.sv
tb/sv/sorted_list_cursor_seek_unit_test.sv
